// ===== rtl/pulse_width_frame_transmitter_assert.svh =====
// Assertion macros, included by pwft_line_fsm.sv.
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_ASSERT_SVH

// Checked outside reset only.
`define PWFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PWFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/pwft_pkg.sv =====
package pwft_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_ONE_LOW       = 3'd0,
    CFG_ZERO_LOW      = 3'd1,
    CFG_BIT_GAP       = 3'd2,
    CFG_PRE_LOW       = 3'd3,
    CFG_PRE_HIGH      = 3'd4,
    CFG_SEND_INTERVAL = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_PRE_LOW  = 5'b00010,
    PH_PRE_HIGH = 5'b00100,
    PH_BIT_LOW  = 5'b01000,
    PH_BIT_HIGH = 5'b10000
  } phase_e;

  localparam int unsigned TicksW    = 16;
  localparam int unsigned IntervalW = 20;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [TicksW-1:0]    OneLowReset   = 16'd1500;
  localparam logic [TicksW-1:0]    ZeroLowReset  = 16'd650;
  localparam logic [TicksW-1:0]    BitGapReset   = 16'd750;
  localparam logic [TicksW-1:0]    PreLowReset   = 16'd7500;
  localparam logic [TicksW-1:0]    PreHighReset  = 16'd3800;
  localparam logic [IntervalW-1:0] IntervalReset = 20'd10000;

  typedef struct packed {
    logic [TicksW-1:0]    one_low;
    logic [TicksW-1:0]    zero_low;
    logic [TicksW-1:0]    bit_gap;
    logic [TicksW-1:0]    pre_low;
    logic [TicksW-1:0]    pre_high;
    logic [IntervalW-1:0] send_interval;
  } cfg_t;

  // sequencer -> frame buffer
  typedef struct packed {
    logic idle;
    logic load;
    logic shift;
  } buf_ctrl_t;

endpackage

// ===== rtl/pulse_width_frame_transmitter.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// in       | in_valid_i / in_ready_o | action_i, byte_index_i, byte_value_i
// out      | out_valid_o/ out_ready_i| line_level_o, write_status_o, frame_active_o
// cfg      | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One item per clock unless the output stalls; inputs, then results, are registered.
// The sequencer updates phase, counters and line as a tick item executes.
// rst_ni is asynchronous; frame bytes, checksum and sequencer clear at once.
// A stalled output holds the execute stage; in_ready_o is low only while both stages
// are full and out_ready_i is low.
module pulse_width_frame_transmitter #(
  parameter int unsigned FRAME_BYTES = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [3:0]                    byte_index_i,
  input  logic [7:0]                    byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_level_o,
  output logic [1:0]                    write_status_o,
  output logic                          frame_active_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [pwft_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pwft_pkg::*;

  cfg_t      cfg_q;
  logic      s1_vld_q, out_vld_q, exec;
  action_e   act_q;
  logic [3:0] idx_q;
  logic [7:0] val_q;
  buf_ctrl_t ctrl;
  logic      tx_bit, line_d, active;
  status_e   status;
  logic      res_line_q, res_active_q;
  logic [1:0] res_status_q;

  assign exec       = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_low       <= OneLowReset;
      cfg_q.zero_low      <= ZeroLowReset;
      cfg_q.bit_gap       <= BitGapReset;
      cfg_q.pre_low       <= PreLowReset;
      cfg_q.pre_high      <= PreHighReset;
      cfg_q.send_interval <= IntervalReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ONE_LOW:       cfg_q.one_low       <= cfg_wdata_i[TicksW-1:0];
        CFG_ZERO_LOW:      cfg_q.zero_low      <= cfg_wdata_i[TicksW-1:0];
        CFG_BIT_GAP:       cfg_q.bit_gap       <= cfg_wdata_i[TicksW-1:0];
        CFG_PRE_LOW:       cfg_q.pre_low       <= cfg_wdata_i[TicksW-1:0];
        CFG_PRE_HIGH:      cfg_q.pre_high      <= cfg_wdata_i[TicksW-1:0];
        CFG_SEND_INTERVAL: cfg_q.send_interval <= cfg_wdata_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_e'(action_i);
      idx_q <= byte_index_i;
      val_q <= byte_value_i;
    end
    if (exec) begin
      res_line_q   <= line_d;
      res_status_q <= status;
      res_active_q <= active;
    end
  end

  pwft_frame_buf #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exec_i       (exec),
    .action_i     (act_q),
    .byte_index_i (idx_q),
    .byte_value_i (val_q),
    .ctrl_i       (ctrl),
    .tx_bit_o     (tx_bit),
    .status_o     (status)
  );

  pwft_line_fsm #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .action_i (act_q),
    .cfg_i    (cfg_q),
    .tx_bit_i (tx_bit),
    .ctrl_o   (ctrl),
    .line_d_o (line_d),
    .active_o (active)
  );

  assign out_valid_o    = out_vld_q;
  assign line_level_o   = res_line_q;
  assign write_status_o = res_status_q;
  assign frame_active_o = res_active_q;

endmodule

// ===== rtl/pwft_frame_buf.sv =====
module pwft_frame_buf #(
  parameter int unsigned FRAME_BYTES = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               exec_i,
  input  pwft_pkg::action_e  action_i,
  input  logic [3:0]         byte_index_i,
  input  logic [7:0]         byte_value_i,
  input  pwft_pkg::buf_ctrl_t ctrl_i,
  output logic               tx_bit_o,
  output pwft_pkg::status_e  status_o
);
  import pwft_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam int unsigned TxW  = 8 * FRAME_BYTES;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);
  localparam logic [4:0] DepthW5 = 5'(FRAME_BYTES);

  logic [7:0]     store_q [FRAME_BYTES];
  logic [7:0]     sum_q, sum_d;
  logic [TxW-1:0] tx_q, tx_load;
  logic [IdxW-1:0] wi;
  logic           in_range, write_ok, clear_ok;

  assign wi       = byte_index_i[IdxW-1:0];
  assign in_range = {1'b0, byte_index_i} < DepthW5;
  assign write_ok = exec_i && (action_i == ACT_WRITE) && ctrl_i.idle && in_range;
  assign clear_ok = exec_i && (action_i == ACT_CLEAR) && ctrl_i.idle;
  // running checksum of every byte except the last
  assign sum_d    = 8'(sum_q + byte_value_i - store_q[wi]);

  always_comb begin
    status_o = ST_OK;
    if (action_i == ACT_WRITE) begin
      if (!ctrl_i.idle) begin
        status_o = ST_BUSY;
      end else if (!in_range) begin
        status_o = ST_RANGE;
      end
    end
  end

  always_comb begin
    tx_load = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      tx_load[8*i +: 8] = store_q[i];
    end
    tx_load[8*(FRAME_BYTES-1) +: 8] = sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (clear_ok) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (write_ok) begin
      store_q[wi] <= byte_value_i;
      if (wi != LastIdx) begin
        sum_q <= sum_d;
      end
    end else if (ctrl_i.load) begin
      store_q[LastIdx] <= sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tx_q <= tx_load;
    end else if (ctrl_i.shift) begin
      tx_q <= {1'b0, tx_q[TxW-1:1]};
    end
  end

  assign tx_bit_o = tx_q[0];

endmodule

// ===== rtl/pwft_line_fsm.sv =====
module pwft_line_fsm #(
  parameter int unsigned FRAME_BYTES = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  pwft_pkg::action_e   action_i,
  input  pwft_pkg::cfg_t      cfg_i,
  input  logic                tx_bit_i,
  output pwft_pkg::buf_ctrl_t ctrl_o,
  output logic                line_d_o,
  output logic                active_o
);
  import pwft_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);

  phase_e               ph_q, ph_d, eff_ph;
  logic [TicksW-1:0]    cnt_q, cnt_d, eff_cnt, cnt_inc, len, len1;
  logic [IdxW-1:0]      byte_q, byte_d;
  logic [2:0]           bit_q, bit_d;
  logic [IntervalW-1:0] idle_cnt_q, idle_cnt_d;
  logic                 line_q, line_d;
  logic                 tick, start, framed, level, adv, shift;

  assign tick    = exec_i && (action_i == ACT_TICK);
  assign start   = tick && (ph_q == PH_IDLE) && (idle_cnt_q >= cfg_i.send_interval);
  assign framed  = tick && ((ph_q != PH_IDLE) || start);
  assign eff_ph  = start ? PH_PRE_LOW : ph_q;
  assign eff_cnt = start ? '0 : cnt_q;
  assign cnt_inc = eff_cnt + 1'b1;
  assign level   = !((eff_ph == PH_PRE_LOW) || (eff_ph == PH_BIT_LOW));

  always_comb begin
    unique case (eff_ph)
      PH_PRE_LOW:  len = cfg_i.pre_low;
      PH_PRE_HIGH: len = cfg_i.pre_high;
      PH_BIT_LOW:  len = tx_bit_i ? cfg_i.one_low : cfg_i.zero_low;
      default:     len = cfg_i.bit_gap;
    endcase
  end

  assign len1 = (len == '0) ? TicksW'(1) : len;
  assign adv  = (cnt_inc >= len1) || (cnt_inc == '0);

  always_comb begin
    ph_d       = ph_q;
    cnt_d      = cnt_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    idle_cnt_d = idle_cnt_q;
    line_d     = line_q;
    shift      = 1'b0;
    if (tick && !framed) begin
      if (idle_cnt_q != '1) begin
        idle_cnt_d = idle_cnt_q + 1'b1;
      end
      line_d = 1'b1;
    end else if (framed) begin
      line_d = level;
      ph_d   = eff_ph;
      cnt_d  = cnt_inc;
      if (adv) begin
        cnt_d = '0;
        unique case (eff_ph)
          PH_PRE_LOW:  ph_d = PH_PRE_HIGH;
          PH_PRE_HIGH: begin
            ph_d   = PH_BIT_LOW;
            byte_d = '0;
            bit_d  = '0;
          end
          PH_BIT_LOW:  ph_d = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            if (bit_q != 3'd7) begin
              bit_d = bit_q + 1'b1;
              ph_d  = PH_BIT_LOW;
              shift = 1'b1;
            end else if (byte_q != LastIdx) begin
              byte_d = byte_q + 1'b1;
              bit_d  = '0;
              ph_d   = PH_BIT_LOW;
              shift  = 1'b1;
            end else begin
              ph_d       = PH_IDLE;
              byte_d     = '0;
              bit_d      = '0;
              idle_cnt_d = '0;
            end
          end
          default: ph_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_IDLE;
      cnt_q      <= '0;
      byte_q     <= '0;
      bit_q      <= '0;
      idle_cnt_q <= '0;
      line_q     <= 1'b1;
    end else begin
      ph_q       <= ph_d;
      cnt_q      <= cnt_d;
      byte_q     <= byte_d;
      bit_q      <= bit_d;
      idle_cnt_q <= idle_cnt_d;
      line_q     <= line_d;
    end
  end

  assign ctrl_o.idle  = (ph_q == PH_IDLE);
  assign ctrl_o.load  = start;
  assign ctrl_o.shift = shift;
  assign line_d_o     = line_d;
  assign active_o     = tick ? framed : (ph_q != PH_IDLE);

  `include "pulse_width_frame_transmitter_assert.svh"

  `PWFT_ASSERT(a_start_leaves_idle, start |=> (ph_q != PH_IDLE), "frame start did not leave idle")
  `PWFT_ASSERT(a_idle_tick_high, (tick && !framed) |=> line_q, "idle tick did not drive high")
  `PWFT_ASSERT_ALWAYS(a_preamble_pos_zero,
    ((ph_q == PH_PRE_LOW) || (ph_q == PH_PRE_HIGH)) |-> ((byte_q == '0) && (bit_q == '0)),
    "bit position not cleared during preamble")

endmodule

// ===== tb/pulse_width_frame_transmitter_test.sv =====
module pulse_width_frame_transmitter_test;
  import pwft_pkg::*;

  localparam int unsigned FrameBytes = 6;
  localparam int StallLimit = 1000;
  localparam int RandomItems = 240;
  localparam int RandomRounds = 3;
  localparam int ReportLimit = 10;
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic    line;
    status_e status;
    logic    active;
  } line_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i = ACT_TICK;
  logic [3:0]          byte_index_i = '0;
  logic [7:0]          byte_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                line_level_o;
  logic [1:0]          write_status_o;
  logic                frame_active_o;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  pulse_width_frame_transmitter #(
    .FRAME_BYTES(FrameBytes)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .byte_index_i  (byte_index_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_level_o  (line_level_o),
    .write_status_o(write_status_o),
    .frame_active_o(frame_active_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // transmitter state as the line should see it
  logic [7:0]  frame_bytes [FrameBytes];
  phase_e      tx_phase = PH_IDLE;
  logic [15:0] phase_ticks = '0;
  logic [3:0]  byte_pos = '0;
  logic [2:0]  bit_pos = '0;
  logic [19:0] idle_ticks = '0;
  logic        line_reg = 1'b1;

  logic [15:0] one_low = OneLowReset;
  logic [15:0] zero_low = ZeroLowReset;
  logic [15:0] bit_gap = BitGapReset;
  logic [15:0] pre_low = PreLowReset;
  logic [15:0] pre_high = PreHighReset;
  logic [19:0] send_interval = IntervalReset;

  line_result_t line_results_q [$];

  int n_in = 0;
  int n_out = 0;
  int n_bad = 0;
  int n_frames = 0;
  int n_settings = 0;
  int burst_left = 0;
  int unsigned rx_cycle = 0;

  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] phase_length();
    case (tx_phase)
      PH_PRE_LOW:  return at_least_one(pre_low);
      PH_PRE_HIGH: return at_least_one(pre_high);
      PH_BIT_LOW:  return at_least_one(frame_bytes[byte_pos][bit_pos] ? one_low : zero_low);
      default:     return at_least_one(bit_gap);
    endcase
  endfunction

  task next_phase();
    phase_ticks = '0;
    case (tx_phase)
      PH_PRE_LOW: tx_phase = PH_PRE_HIGH;
      PH_PRE_HIGH: begin
        tx_phase = PH_BIT_LOW;
        byte_pos = '0;
        bit_pos = '0;
      end
      PH_BIT_LOW: tx_phase = PH_BIT_HIGH;
      default: begin
        if (bit_pos != 3'd7) begin
          bit_pos++;
          tx_phase = PH_BIT_LOW;
        end else if (byte_pos + 1 < FrameBytes) begin
          byte_pos++;
          bit_pos = '0;
          tx_phase = PH_BIT_LOW;
        end else begin
          tx_phase = PH_IDLE;
          byte_pos = '0;
          bit_pos = '0;
          idle_ticks = '0;
        end
      end
    endcase
  endtask

  task automatic apply_item(input action_e act, input logic [3:0] idx, input logic [7:0] val,
                            output line_result_t res);
    logic        framed;
    logic [7:0]  sum;
    logic [15:0] len;
    res.status = ST_OK;
    res.active = (tx_phase != PH_IDLE);
    case (act)
      ACT_TICK: begin
        framed = 1'b1;
        if (tx_phase == PH_IDLE) begin
          if (idle_ticks >= send_interval) begin
            // checksum lands in the last byte, this tick is already preamble low
            sum = '0;
            for (int i = 0; i < FrameBytes - 1; i++) sum += frame_bytes[i];
            frame_bytes[FrameBytes-1] = sum;
            tx_phase = PH_PRE_LOW;
            phase_ticks = '0;
            n_frames++;
          end else begin
            if (idle_ticks != '1) idle_ticks++;
            line_reg = 1'b1;
            framed = 1'b0;
          end
        end
        if (framed) begin
          len = phase_length();
          phase_ticks++;
          line_reg = !(tx_phase == PH_PRE_LOW || tx_phase == PH_BIT_LOW);
          if (phase_ticks >= len || phase_ticks == '0) next_phase();
        end
        res.active = framed;
      end
      ACT_WRITE: begin
        if (tx_phase != PH_IDLE) res.status = ST_BUSY;
        else if (idx >= FrameBytes) res.status = ST_RANGE;
        else frame_bytes[idx] = val;
      end
      ACT_CLEAR: begin
        if (tx_phase == PH_IDLE) frame_bytes = '{default: 8'h00};
      end
      default: ;
    endcase
    res.line = line_reg;
  endtask

  task automatic send_item(input action_e act, input logic [3:0] idx, input logic [7:0] val);
    line_result_t res;
    int gap;
    gap = 0;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(200, 50);
      end else begin
        burst_left = $urandom_range(24, 1);
        gap = $urandom_range(8, 1);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i <= act;
    byte_index_i <= idx;
    byte_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(act, idx, val, res);
    line_results_q.push_back(res);
    n_in++;
  endtask

  task settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (line_results_q.size() != 0) @(posedge clk_i);
  endtask

  task write_reg(input logic [2:0] idx, input logic [19:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ONE_LOW:       one_low = data[15:0];
      CFG_ZERO_LOW:      zero_low = data[15:0];
      CFG_BIT_GAP:       bit_gap = data[15:0];
      CFG_PRE_LOW:       pre_low = data[15:0];
      CFG_PRE_HIGH:      pre_high = data[15:0];
      CFG_SEND_INTERVAL: send_interval = data;
      default: ;
    endcase
  endtask

  task set_timing(input logic [19:0] one, input logic [19:0] zero, input logic [19:0] gap,
                  input logic [19:0] plow, input logic [19:0] phigh,
                  input logic [19:0] interval);
    settle();
    write_reg(CFG_ONE_LOW, one);
    write_reg(CFG_ZERO_LOW, zero);
    write_reg(CFG_BIT_GAP, gap);
    write_reg(CFG_PRE_LOW, plow);
    write_reg(CFG_PRE_HIGH, phigh);
    write_reg(CFG_SEND_INTERVAL, interval);
    n_settings++;
  endtask

  task tick_until_active();
    do send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    while (tx_phase == PH_IDLE);
  endtask

  task run_to_idle();
    while (tx_phase != PH_IDLE)
      send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task write_random_frame();
    for (int i = 0; i < FrameBytes; i++) send_item(ACT_WRITE, 4'(i), 8'($urandom_range(255)));
  endtask

  task test_reset_defaults();
    write_random_frame();
    repeat (20) send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    settle();
    write_reg(CFG_SEND_INTERVAL, 20'd0);
    // reset preamble length, then finish the frame on short lengths
    tick_until_active();
    repeat (40) send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    set_timing(20'd2, 20'd1, 20'd1, 20'd1, 20'd1, 20'd2);
    run_to_idle();
  endtask

  task test_frame_edits();
    set_timing(20'd3, 20'd1, 20'd2, 20'd4, 20'd2, 20'd5);
    send_item(ACT_WRITE, 4'd0, 8'h00);
    send_item(ACT_WRITE, 4'd1, 8'hFF);
    send_item(ACT_WRITE, 4'd2, 8'hA5);
    send_item(ACT_WRITE, 4'd3, 8'h81);
    send_item(ACT_WRITE, 4'd4, 8'h5A);
    send_item(ACT_WRITE, 4'd5, 8'h33);
    send_item(ACT_WRITE, 4'd6, 8'h77);
    send_item(ACT_WRITE, 4'd15, 8'hFF);
    send_item(ACT_NONE, 4'd9, 8'hC3);
    send_item(ACT_CLEAR, 4'd0, 8'h00);
    send_item(ACT_WRITE, 4'd0, 8'h01);
    send_item(ACT_WRITE, 4'd4, 8'h80);
    send_item(ACT_WRITE, 4'd5, 8'hFF);
    tick_until_active();
    // refused while the frame is out; busy wins over a bad index
    send_item(ACT_WRITE, 4'd2, 8'h11);
    send_item(ACT_WRITE, 4'd15, 8'h00);
    send_item(ACT_CLEAR, 4'd7, 8'h3C);
    send_item(ACT_NONE, 4'd0, 8'hFF);
    run_to_idle();
    send_item(ACT_NONE, 4'd15, 8'h00);
    send_item(ACT_CLEAR, 4'd15, 8'hFF);
  endtask

  task test_zero_lengths();
    set_timing(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    write_random_frame();
    tick_until_active();
    run_to_idle();
    // upper data bits must be dropped on the 16-bit registers
    set_timing(20'hF0002, 20'hA0001, 20'h50001, 20'hF0004, 20'h10002, 20'd3);
    write_reg(CfgSpareLo, 20'hFFFFF);
    write_reg(CfgSpareHi, 20'h00000);
    write_random_frame();
    tick_until_active();
    run_to_idle();
  endtask

  task test_extreme_lengths();
    set_timing(20'd1, 20'd1, 20'd1, 20'hFFFF, 20'd1, 20'd1);
    write_random_frame();
    tick_until_active();
    repeat (50) send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    settle();
    write_reg(CFG_PRE_LOW, 20'd1);
    run_to_idle();
    set_timing(20'hFFFF, 20'hFFFF, 20'hFFFF, 20'd1, 20'hFFFF, 20'hFFFFF);
    repeat (40) send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    write_random_frame();
    repeat (20) send_item(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task test_random_traffic();
    int pick;
    int counted;
    action_e act;
    logic [3:0] idx;
    for (int r = 0; r < RandomRounds; r++) begin
      set_timing(20'($urandom_range(3)), 20'($urandom_range(3)), 20'($urandom_range(3)),
                 20'($urandom_range(8)), 20'($urandom_range(8)),
                 20'($urandom_range(40)));
      counted = 0;
      while (counted < RandomItems / RandomRounds) begin
        pick = $urandom_range(99);
        if (pick < 72) act = ACT_TICK;
        else if (pick < 88) act = ACT_WRITE;
        else if (pick < 93) act = ACT_CLEAR;
        else act = ACT_NONE;
        if (act == ACT_WRITE && $urandom_range(4) != 0) idx = 4'($urandom_range(FrameBytes - 1));
        else idx = 4'($urandom_range(15));
        send_item(act, idx, 8'($urandom_range(255)));
        if (act != ACT_NONE) counted++;
      end
      run_to_idle();
    end
  endtask

  // receiver: ready always, mostly, periodic, then mostly stalled
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(3) != 0);
      2'd2: out_ready_i <= (rx_cycle[2:0] != 3'd0);
      default: out_ready_i <= ($urandom_range(4) == 0);
    endcase
  end

  task note_mismatch(input string msg);
    n_bad++;
    if (n_bad <= ReportLimit) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    line_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (line_results_q.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer: line %0b status %0d active %0b",
                                line_level_o, write_status_o, frame_active_o));
      end else begin
        want = line_results_q.pop_front();
        if (want.line !== line_level_o || want.status !== write_status_o ||
            want.active !== frame_active_o) begin
          note_mismatch($sformatf(
            "result %0d: expected line %0b status %0d active %0b, got %0b %0d %0b",
            n_out, want.line, want.status, want.active,
            line_level_o, write_status_o, frame_active_o));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    frame_bytes = '{default: 8'h00};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_frame_edits();
    test_zero_lengths();
    test_extreme_lengths();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk_i);
    $display("%0d items in, %0d results checked, %0d mismatches, %0d frames on the line",
             n_in, n_out, n_bad, n_frames);
    $display("%0d timing settings: reset values, zero, one and full-scale lengths, random",
             n_settings);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
